// ----- hdl/blfb_pkg.sv -----
`timescale 1ns / 1ps
package blfb_pkg;

    localparam int UNIT_LOG2 = 14;
    localparam int UNIT      = 1 << UNIT_LOG2;
    localparam int AXW       = 16;
    localparam int NORM_BITS = 30;
    localparam int EW        = NORM_BITS + 1;
    localparam int NRB       = NORM_BITS + 1;
    localparam int QB        = UNIT_LOG2 + 1;
    localparam int DEN_W     = NRB + 1;
    localparam int NUM_W     = NORM_BITS + QB + 1;

    typedef logic signed [AXW-1:0] t_axis;

    function automatic t_axis sign_sat(input logic neg, input logic [AXW:0] q);
        logic [AXW:0] s;
        s = (q > (AXW+1)'(UNIT)) ? (AXW+1)'(UNIT) : q;
        return neg ? -t_axis'(s[AXW-1:0]) : t_axis'(s[AXW-1:0]);
    endfunction

endpackage

// ----- hdl/beam_local_frame_builder_unit.sv -----
`timescale 1ns / 1ps
// Beam element local frame: takes one element (two Q16.16 end nodes and an optional Q2.14
// reference vector) in every cycle that o_stall is low and returns its unsigned Q17.16 length
// and three Q2.14 unit axes. Its depth is set by the bit-per-stage square roots (33 stages for
// the length, 31 for each of the two vector norms) and the 15-stage restoring dividers. A stall
// while a result waits at the output freezes the whole pipeline; nothing in flight is lost.
module beam_local_frame_builder_unit import blfb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_node_a_x,
    input  logic signed [31:0] i_node_a_y,
    input  logic signed [31:0] i_node_a_z,
    input  logic signed [31:0] i_node_b_x,
    input  logic signed [31:0] i_node_b_y,
    input  logic signed [31:0] i_node_b_z,
    input  logic               i_use_reference,
    input  logic signed [15:0] i_ref_x,
    input  logic signed [15:0] i_ref_y,
    input  logic signed [15:0] i_ref_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [32:0]        o_length,
    output logic signed [15:0] o_axis1_x,
    output logic signed [15:0] o_axis1_y,
    output logic signed [15:0] o_axis1_z,
    output logic signed [15:0] o_axis2_x,
    output logic signed [15:0] o_axis2_y,
    output logic signed [15:0] o_axis2_z,
    output logic signed [15:0] o_axis3_x,
    output logic signed [15:0] o_axis3_y,
    output logic signed [15:0] o_axis3_z,
    output logic               o_degenerate
);

    localparam int CW  = 32;
    localparam int DW  = CW + 1;
    localparam int LRB = DW;
    localparam int RW  = 16;
    localparam int WW  = EW + RW;
    localparam int PW  = 2 * AXW;
    localparam int SW1 = LRB + 1 + 3 * RW;
    localparam int LSW = 3 * DW + 1 + 3 * RW;
    localparam int SW2 = LRB + 1 + 3 * AXW + 1;

    logic                     w_en;

    logic                     r0_vld;
    logic [2:0][CW-1:0]       r0_a, r0_b;
    logic                     r0_use;
    logic [2:0][RW-1:0]       r0_ref;

    logic [2:0][DW-1:0]       c_d;
    logic [2:0][CW-1:0]       c_dmag;
    logic                     r1_vld;
    logic [2:0][DW-1:0]       r1_d;
    logic [2:0][CW-1:0]       r1_mag;
    logic                     r1_use;
    logic [2:0][RW-1:0]       r1_ref;

    logic                     r2_vld;
    logic [2:0][2*CW-1:0]     r2_sq;
    logic [2:0][DW-1:0]       r2_d;
    logic                     r2_use;
    logic [2:0][RW-1:0]       r2_ref;

    logic                     r3_vld;
    logic [2*LRB-1:0]         r3_sum;
    logic [2:0][DW-1:0]       r3_d;
    logic                     r3_use;
    logic [2:0][RW-1:0]       r3_ref;

    logic                     l_vld;
    logic [LRB-1:0]           l_len;
    logic [LSW-1:0]           l_side;
    logic [2:0][DW-1:0]       l_d;
    logic                     l_use;
    logic [2:0][RW-1:0]       l_ref;

    logic                     v1_vld;
    logic [2:0][EW-1:0]       v1_e;
    logic [2:0][AXW-1:0]      v1_u;
    logic                     v1_nz;
    logic [SW1-1:0]           v1_side;
    logic [LRB-1:0]           v1_len;
    logic                     v1_use;
    logic [2:0][RW-1:0]       v1_ref;

    logic signed [WW-1:0]     c_pa [3];
    logic signed [WW-1:0]     c_pb [3];
    logic [EW-1:0]            c_my, c_mz;
    logic                     r4_vld;
    logic signed [WW-1:0]     r4_pa [3];
    logic signed [WW-1:0]     r4_pb [3];
    logic [2:0][EW-1:0]       r4_e;
    logic                     r4_ysel;
    logic                     r4_use;
    logic                     r4_nz;
    logic [LRB-1:0]           r4_len;
    logic [2:0][AXW-1:0]      r4_u;

    logic [2:0][WW-1:0]       c_w;
    logic                     r5_vld;
    logic [2:0][WW-1:0]       r5_w;
    logic                     r5_use;
    logic                     r5_nz;
    logic [LRB-1:0]           r5_len;
    logic [2:0][AXW-1:0]      r5_u;

    logic                     v2_vld;
    logic [2:0][AXW-1:0]      v2_u;
    logic                     v2_nz;
    logic [SW2-1:0]           v2_side;
    logic [LRB-1:0]           v2_len;
    logic                     v2_use;
    logic [2:0][AXW-1:0]      v2_u1;
    logic                     v2_nz1;

    logic [2:0][AXW-1:0]      c_ca, c_cb;
    logic signed [PW-1:0]     c_qa [3];
    logic signed [PW-1:0]     c_qb [3];
    logic                     r6_vld;
    logic signed [PW-1:0]     r6_qa [3];
    logic signed [PW-1:0]     r6_qb [3];
    logic [2:0][AXW-1:0]      r6_u1, r6_u2;
    logic                     r6_use, r6_nz1, r6_nz2;
    logic [LRB-1:0]           r6_len;

    logic [2:0][AXW-1:0]      c_x;
    logic                     c_deg;
    logic                     r_out_valid;
    logic [LRB-1:0]           r_len;
    logic [2:0][AXW-1:0]      r_ax1, r_ax2, r_ax3;
    logic                     r_deg;

    assign o_stall = r_out_valid && i_stall;
    assign w_en    = !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld      <= 1'b0;
            r1_vld      <= 1'b0;
            r2_vld      <= 1'b0;
            r3_vld      <= 1'b0;
            r4_vld      <= 1'b0;
            r5_vld      <= 1'b0;
            r6_vld      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r0_vld      <= i_valid;
            r1_vld      <= r0_vld;
            r2_vld      <= r1_vld;
            r3_vld      <= r2_vld;
            r4_vld      <= v1_vld;
            r5_vld      <= r4_vld;
            r6_vld      <= v2_vld;
            r_out_valid <= r6_vld;
        end
    end

    always_comb begin
        logic [DW-1:0] dm;
        for (int j = 0; j < 3; j++) begin
            c_d[j]    = DW'($signed(r0_b[j])) - DW'($signed(r0_a[j]));
            dm        = c_d[j][DW-1] ? -c_d[j] : c_d[j];
            c_dmag[j] = dm[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_a   <= {i_node_a_z, i_node_a_y, i_node_a_x};
            r0_b   <= {i_node_b_z, i_node_b_y, i_node_b_x};
            r0_use <= i_use_reference;
            r0_ref <= {i_ref_z, i_ref_y, i_ref_x};

            r1_d   <= c_d;
            r1_mag <= c_dmag;
            r1_use <= r0_use;
            r1_ref <= r0_ref;

            for (int j = 0; j < 3; j++) begin
                r2_sq[j] <= r1_mag[j] * r1_mag[j];
            end
            r2_d   <= r1_d;
            r2_use <= r1_use;
            r2_ref <= r1_ref;

            r3_sum <= (2*LRB)'(r2_sq[0]) + (2*LRB)'(r2_sq[1]) + (2*LRB)'(r2_sq[2]);
            r3_d   <= r2_d;
            r3_use <= r2_use;
            r3_ref <= r2_ref;
        end
    end

    blfb_sqrt_pipe #(
        .RB (LRB),
        .SW (LSW)
    ) u_len_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r3_vld),
        .i_rad   (r3_sum),
        .i_side  ({r3_d, r3_use, r3_ref}),
        .o_valid (l_vld),
        .o_root  (l_len),
        .o_side  (l_side)
    );

    assign {l_d, l_use, l_ref} = l_side;

    blfb_unitvec #(
        .IW (DW),
        .SW (SW1)
    ) u_axis1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (l_vld),
        .i_vec   (l_d),
        .i_side  ({l_len, l_use, l_ref}),
        .o_valid (v1_vld),
        .o_e     (v1_e),
        .o_u     (v1_u),
        .o_nz    (v1_nz),
        .o_side  (v1_side)
    );

    assign {v1_len, v1_use, v1_ref} = v1_side;

    always_comb begin
        c_pa[0] = $signed(v1_e[1]) * $signed(v1_ref[2]);
        c_pb[0] = $signed(v1_e[2]) * $signed(v1_ref[1]);
        c_pa[1] = $signed(v1_e[2]) * $signed(v1_ref[0]);
        c_pb[1] = $signed(v1_e[0]) * $signed(v1_ref[2]);
        c_pa[2] = $signed(v1_e[0]) * $signed(v1_ref[1]);
        c_pb[2] = $signed(v1_e[1]) * $signed(v1_ref[0]);
        c_my    = v1_e[1][EW-1] ? -v1_e[1] : v1_e[1];
        c_mz    = v1_e[2][EW-1] ? -v1_e[2] : v1_e[2];
    end

    always_comb begin
        if (r4_use) begin
            for (int j = 0; j < 3; j++) begin
                c_w[j] = WW'(r4_pa[j] - r4_pb[j]);
            end
        end else if (r4_ysel) begin
            c_w[0] = -WW'($signed(r4_e[1]));
            c_w[1] = WW'($signed(r4_e[0]));
            c_w[2] = '0;
        end else begin
            c_w[0] = WW'($signed(r4_e[2]));
            c_w[1] = '0;
            c_w[2] = -WW'($signed(r4_e[0]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r4_pa[j] <= c_pa[j];
                r4_pb[j] <= c_pb[j];
            end
            r4_e    <= v1_e;
            r4_ysel <= c_my > c_mz;
            r4_use  <= v1_use;
            r4_nz   <= v1_nz;
            r4_len  <= v1_len;
            r4_u    <= v1_u;

            r5_w    <= c_w;
            r5_use  <= r4_use;
            r5_nz   <= r4_nz;
            r5_len  <= r4_len;
            r5_u    <= r4_u;
        end
    end

    blfb_unitvec #(
        .IW (WW),
        .SW (SW2)
    ) u_axis_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r5_vld),
        .i_vec   (r5_w),
        .i_side  ({r5_len, r5_use, r5_u, r5_nz}),
        .o_valid (v2_vld),
        .o_e     (),
        .o_u     (v2_u),
        .o_nz    (v2_nz),
        .o_side  (v2_side)
    );

    assign {v2_len, v2_use, v2_u1, v2_nz1} = v2_side;

    always_comb begin
        c_ca    = v2_use ? v2_u : v2_u1;
        c_cb    = v2_use ? v2_u1 : v2_u;
        c_qa[0] = $signed(c_ca[1]) * $signed(c_cb[2]);
        c_qb[0] = $signed(c_ca[2]) * $signed(c_cb[1]);
        c_qa[1] = $signed(c_ca[2]) * $signed(c_cb[0]);
        c_qb[1] = $signed(c_ca[0]) * $signed(c_cb[2]);
        c_qa[2] = $signed(c_ca[0]) * $signed(c_cb[1]);
        c_qb[2] = $signed(c_ca[1]) * $signed(c_cb[0]);
    end

    always_comb begin
        logic signed [PW:0] diff;
        logic [PW:0]        m;
        logic [PW:0]        q;
        for (int j = 0; j < 3; j++) begin
            diff   = (PW+1)'(r6_qa[j]) - (PW+1)'(r6_qb[j]);
            m      = diff[PW] ? -diff : diff;
            q      = (m + (PW+1)'(1 << (UNIT_LOG2 - 1))) >> UNIT_LOG2;
            c_x[j] = sign_sat(diff[PW], q[AXW:0]);
        end
        c_deg = !r6_nz1 || (r6_use && !r6_nz2);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r6_qa[j] <= c_qa[j];
                r6_qb[j] <= c_qb[j];
            end
            r6_u1  <= v2_u1;
            r6_u2  <= v2_u;
            r6_use <= v2_use;
            r6_nz1 <= v2_nz1;
            r6_nz2 <= v2_nz;
            r6_len <= v2_len;

            r_len  <= r6_len;
            r_deg  <= c_deg;
            if (c_deg) begin
                r_ax1 <= '0;
                r_ax2 <= '0;
                r_ax3 <= '0;
            end else if (r6_use) begin
                r_ax1 <= r6_u1;
                r_ax2 <= c_x;
                r_ax3 <= r6_u2;
            end else begin
                r_ax1 <= r6_u1;
                r_ax2 <= r6_u2;
                r_ax3 <= c_x;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_length     = r_len;
    assign o_axis1_x    = r_ax1[0];
    assign o_axis1_y    = r_ax1[1];
    assign o_axis1_z    = r_ax1[2];
    assign o_axis2_x    = r_ax2[0];
    assign o_axis2_y    = r_ax2[1];
    assign o_axis2_z    = r_ax2[2];
    assign o_axis3_x    = r_ax3[0];
    assign o_axis3_y    = r_ax3[1];
    assign o_axis3_z    = r_ax3[2];
    assign o_degenerate = r_deg;

endmodule

// ----- hdl/blfb_sqrt_pipe.sv -----
`timescale 1ns / 1ps
module blfb_sqrt_pipe #(
    parameter int RB = 33,
    parameter int SW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [2*RB-1:0] i_rad,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output logic [RB-1:0]   o_root,
    output logic [SW-1:0]   o_side
);

    localparam int W = RB + 2;

    logic [W-1:0]    r_rem  [RB];
    logic [RB-1:0]   r_root [RB];
    logic [2*RB-1:0] r_rad  [RB];
    logic [SW-1:0]   r_side [RB];
    logic [RB-1:0]   r_vld;

    for (genvar k = 0; k < RB; k++) begin : g_stage
        logic [W-1:0]    rem_in;
        logic [W-1:0]    rem_sh;
        logic [W-1:0]    trial;
        logic [RB-1:0]   root_in;
        logic [2*RB-1:0] rad_in;
        logic [SW-1:0]   side_in;
        logic            vld_in;
        logic            ge;

        if (k == 0) begin : g_head
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
            assign side_in = i_side;
            assign vld_in  = i_valid;
        end else begin : g_body
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
            assign side_in = r_side[k-1];
            assign vld_in  = r_vld[k-1];
        end

        assign rem_sh = {rem_in[W-3:0], rad_in[2*RB-1 -: 2]};
        assign trial  = {root_in, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? rem_sh - trial : rem_sh;
                r_root[k] <= {root_in[RB-2:0], ge};
                r_rad[k]  <= {rad_in[2*RB-3:0], 2'b00};
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[RB-1];
    assign o_root  = r_root[RB-1];
    assign o_side  = r_side[RB-1];

endmodule

// ----- hdl/blfb_div_pipe.sv -----
`timescale 1ns / 1ps
module blfb_div_pipe import blfb_pkg::*; #(
    parameter int SW = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [2:0][NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0]      i_den,
    input  logic [SW-1:0]         i_side,
    output logic                  o_valid,
    output logic [2:0][QB-1:0]    o_quo,
    output logic [SW-1:0]         o_side
);

    logic [2:0][NUM_W-1:0] r_rem  [QB];
    logic [2:0][QB-1:0]    r_quo  [QB];
    logic [DEN_W-1:0]      r_den  [QB];
    logic [SW-1:0]         r_side [QB];
    logic [QB-1:0]         r_vld;

    for (genvar s = 0; s < QB; s++) begin : g_stage
        logic [2:0][NUM_W-1:0] rem_in;
        logic [2:0][NUM_W-1:0] n_rem;
        logic [2:0][QB-1:0]    quo_in;
        logic [2:0][QB-1:0]    n_quo;
        logic [DEN_W-1:0]      den_in;
        logic [SW-1:0]         side_in;
        logic                  vld_in;
        logic [NUM_W:0]        dsh;

        if (s == 0) begin : g_head
            assign rem_in  = i_num;
            assign quo_in  = '0;
            assign den_in  = i_den;
            assign side_in = i_side;
            assign vld_in  = i_valid;
        end else begin : g_body
            assign rem_in  = r_rem[s-1];
            assign quo_in  = r_quo[s-1];
            assign den_in  = r_den[s-1];
            assign side_in = r_side[s-1];
            assign vld_in  = r_vld[s-1];
        end

        assign dsh = (NUM_W+1)'(den_in) << (QB - 1 - s);

        always_comb begin
            logic ge;
            for (int j = 0; j < 3; j++) begin
                ge       = {1'b0, rem_in[j]} >= dsh;
                n_rem[j] = ge ? rem_in[j] - dsh[NUM_W-1:0] : rem_in[j];
                n_quo[j] = {quo_in[j][QB-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_quo[s]  <= n_quo;
                r_den[s]  <= den_in;
                r_side[s] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[QB-1];
    assign o_quo   = r_quo[QB-1];
    assign o_side  = r_side[QB-1];

endmodule

// ----- hdl/blfb_unitvec.sv -----
`timescale 1ns / 1ps
module blfb_unitvec import blfb_pkg::*; #(
    parameter int IW = 33,
    parameter int SW = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [2:0][IW-1:0]  i_vec,
    input  logic [SW-1:0]       i_side,
    output logic                o_valid,
    output logic [2:0][EW-1:0]  o_e,
    output logic [2:0][AXW-1:0] o_u,
    output logic                o_nz,
    output logic [SW-1:0]       o_side
);

    localparam int BLW = $clog2(IW + 1);
    localparam int KW  = 3 * NORM_BITS + 3 + 1 + SW;

    logic [2:0][IW-1:0]          c_mag;
    logic [IW-1:0]               c_max;
    logic [BLW-1:0]              c_bl;
    logic [2:0][NORM_BITS-1:0]   c_g;
    logic [2:0][2*NORM_BITS-1:0] c_sq;

    logic                        r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld, r7_vld;
    logic [2:0][IW-1:0]          r1_mag, r2_mag;
    logic [IW-1:0]               r1_max;
    logic [BLW-1:0]              r2_bl;
    logic [2:0]                  r1_neg, r2_neg, r3_neg, r4_neg, r5_neg, r6_neg;
    logic                        r2_nz, r3_nz, r4_nz, r5_nz, r6_nz, r7_nz;
    logic [SW-1:0]               r1_side, r2_side, r3_side, r4_side, r5_side, r6_side;
    logic [SW-1:0]               r7_side;
    logic [2:0][NORM_BITS-1:0]   r3_g, r4_g, r5_g, r6_g;
    logic [2:0][2*NORM_BITS-1:0] r4_sq;
    logic [2*NRB-1:0]            r5_sum;
    logic [2:0][NUM_W-1:0]       r6_num;
    logic [DEN_W-1:0]            r6_den;
    logic [2:0][EW-1:0]          r7_e;
    logic [2:0][AXW-1:0]         r7_u;

    logic                        sq_vld;
    logic [NRB-1:0]              sq_root;
    logic [KW-1:0]               sq_side;
    logic [2:0][NORM_BITS-1:0]   s_g;
    logic [2:0]                  s_neg;
    logic                        s_nz;
    logic [SW-1:0]               s_side;

    logic                        dv_vld;
    logic [2:0][QB-1:0]          dv_quo;
    logic [KW-1:0]               dv_side;
    logic [2:0][NORM_BITS-1:0]   d_g;
    logic [2:0]                  d_neg;
    logic                        d_nz;
    logic [SW-1:0]               d_side;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            c_mag[j] = i_vec[j][IW-1] ? -i_vec[j] : i_vec[j];
        end
        c_max = c_mag[0];
        if (c_mag[1] > c_max) begin
            c_max = c_mag[1];
        end
        if (c_mag[2] > c_max) begin
            c_max = c_mag[2];
        end
    end

    always_comb begin
        c_bl = '0;
        for (int i = 0; i < IW; i++) begin
            if (r1_max[i]) begin
                c_bl = BLW'(i + 1);
            end
        end
    end

    always_comb begin
        logic [IW+NORM_BITS-1:0] ext;
        for (int j = 0; j < 3; j++) begin
            ext    = {r2_mag[j], NORM_BITS'(0)} >> r2_bl;
            c_g[j] = ext[NORM_BITS-1:0];
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            c_sq[j] = r3_g[j] * r3_g[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= sq_vld;
            r7_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag  <= c_mag;
            r1_max  <= c_max;
            r1_neg  <= {i_vec[2][IW-1], i_vec[1][IW-1], i_vec[0][IW-1]};
            r1_side <= i_side;

            r2_mag  <= r1_mag;
            r2_bl   <= c_bl;
            r2_nz   <= |r1_max;
            r2_neg  <= r1_neg;
            r2_side <= r1_side;

            r3_g    <= c_g;
            r3_neg  <= r2_neg;
            r3_nz   <= r2_nz;
            r3_side <= r2_side;

            r4_sq   <= c_sq;
            r4_g    <= r3_g;
            r4_neg  <= r3_neg;
            r4_nz   <= r3_nz;
            r4_side <= r3_side;

            r5_sum  <= (2*NRB)'(r4_sq[0]) + (2*NRB)'(r4_sq[1]) + (2*NRB)'(r4_sq[2]);
            r5_g    <= r4_g;
            r5_neg  <= r4_neg;
            r5_nz   <= r4_nz;
            r5_side <= r4_side;
        end
    end

    blfb_sqrt_pipe #(
        .RB (NRB),
        .SW (KW)
    ) u_norm_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r5_vld),
        .i_rad   (r5_sum),
        .i_side  ({r5_g, r5_neg, r5_nz, r5_side}),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    assign {s_g, s_neg, s_nz, s_side} = sq_side;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r6_num[j] <= NUM_W'({s_g[j], QB'(0)}) + NUM_W'(sq_root);
            end
            r6_den  <= {sq_root, 1'b0};
            r6_g    <= s_g;
            r6_neg  <= s_neg;
            r6_nz   <= s_nz;
            r6_side <= s_side;
        end
    end

    blfb_div_pipe #(
        .SW (KW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r6_vld),
        .i_num   (r6_num),
        .i_den   (r6_den),
        .i_side  ({r6_g, r6_neg, r6_nz, r6_side}),
        .o_valid (dv_vld),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    assign {d_g, d_neg, d_nz, d_side} = dv_side;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r7_u[j] <= sign_sat(d_neg[j], (AXW+1)'(dv_quo[j]));
                r7_e[j] <= d_neg[j] ? -EW'(d_g[j]) : EW'(d_g[j]);
            end
            r7_nz   <= d_nz;
            r7_side <= d_side;
        end
    end

    assign o_valid = r7_vld;
    assign o_e     = r7_e;
    assign o_u     = r7_u;
    assign o_nz    = r7_nz;
    assign o_side  = r7_side;

endmodule

// ----- sim/tb_beam_local_frame_builder_unit.sv -----
`timescale 1ns / 1ps
module tb_beam_local_frame_builder_unit;
    import blfb_pkg::*;

    typedef longint vec3_t [3];

    typedef struct {
        logic signed [31:0] ax, ay, az, bx, by, bz;
        logic               use_ref;
        logic signed [15:0] rx, ry, rz;
        bit                 pause;
    } element_t;

    typedef struct {
        logic [32:0] len;
        longint      axis [9];
        logic        degen;
    } frame_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_node_a_x = '0, i_node_a_y = '0, i_node_a_z = '0;
    logic signed [31:0] i_node_b_x = '0, i_node_b_y = '0, i_node_b_z = '0;
    logic               i_use_reference = 1'b0;
    logic signed [15:0] i_ref_x = '0, i_ref_y = '0, i_ref_z = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [32:0]        o_length;
    logic signed [15:0] o_axis1_x, o_axis1_y, o_axis1_z;
    logic signed [15:0] o_axis2_x, o_axis2_y, o_axis2_z;
    logic signed [15:0] o_axis3_x, o_axis3_y, o_axis3_z;
    logic               o_degenerate;

    beam_local_frame_builder_unit dut (.*);

    element_t pending_elements [$];
    frame_t   frames_due [$];
    int       errors = 0;
    int       n_sent = 0;
    int       cycles = 0;
    bit       quiet;

    assign quiet = pending_elements.size() < 50;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint clamp_unit(longint v);
        if (v > UNIT) return UNIT;
        if (v < -UNIT) return -UNIT;
        return v;
    endfunction

    function automatic longint round_div(longint num, longint unsigned den);
        longint unsigned m, q;
        m = magnitude(num);
        q = (2 * m + den) / (2 * den);
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [33:0] floor_sqrt(logic [67:0] x);
        logic [71:0] root, rem, trial;
        root = '0;
        rem  = '0;
        for (int i = 33; i >= 0; i--) begin
            rem   = (rem << 2) | x[2*i +: 2];
            trial = (root << 2) | 72'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 72'd1;
            end else begin
                root = root << 1;
            end
        end
        return root[33:0];
    endfunction

    function automatic bit normalise(input vec3_t v, output vec3_t e, output vec3_t u);
        longint unsigned m, g, t, n;
        int bl;
        m = 0;
        t = 0;
        bl = 0;
        e = '{0, 0, 0};
        u = '{0, 0, 0};
        for (int i = 0; i < 3; i++)
            if (magnitude(v[i]) > m) m = magnitude(v[i]);
        if (m == 0) return 0;
        while (bl < 64 && (m >> bl) != 0) bl++;
        for (int i = 0; i < 3; i++) begin
            g = magnitude(v[i]);
            if (bl < NORM_BITS) g = g << (NORM_BITS - bl);
            else g = g >> (bl - NORM_BITS);
            e[i] = v[i] < 0 ? -longint'(g) : longint'(g);
            t += g * g;
        end
        n = floor_sqrt({4'b0, t});
        for (int i = 0; i < 3; i++)
            u[i] = clamp_unit(round_div(e[i] * UNIT, n));
        return 1;
    endfunction

    function automatic vec3_t cross_unit(vec3_t a, vec3_t b);
        vec3_t o;
        o[0] = clamp_unit(round_div(a[1] * b[2] - a[2] * b[1], UNIT));
        o[1] = clamp_unit(round_div(a[2] * b[0] - a[0] * b[2], UNIT));
        o[2] = clamp_unit(round_div(a[0] * b[1] - a[1] * b[0], UNIT));
        return o;
    endfunction

    function automatic frame_t build_frame(element_t el);
        frame_t f;
        vec3_t d, e, w, tmp, r, a1, a2, a3;
        logic [67:0] sumsq;
        longint unsigned m;
        d[0] = longint'(el.bx) - longint'(el.ax);
        d[1] = longint'(el.by) - longint'(el.ay);
        d[2] = longint'(el.bz) - longint'(el.az);
        sumsq = '0;
        for (int i = 0; i < 3; i++) begin
            m = magnitude(d[i]);
            sumsq += {4'b0, m * m};
        end
        f.len = floor_sqrt(sumsq);
        f.degen = 1'b0;
        a2 = '{0, 0, 0};
        a3 = '{0, 0, 0};
        if (!normalise(d, e, a1)) begin
            f.degen = 1'b1;
        end else if (el.use_ref) begin
            r[0] = el.rx;
            r[1] = el.ry;
            r[2] = el.rz;
            w[0] = e[1] * r[2] - e[2] * r[1];
            w[1] = e[2] * r[0] - e[0] * r[2];
            w[2] = e[0] * r[1] - e[1] * r[0];
            if (!normalise(w, tmp, a3)) f.degen = 1'b1;
            else a2 = cross_unit(a3, a1);
        end else begin
            if (magnitude(e[1]) > magnitude(e[2])) w = '{-e[1], e[0], 0};
            else w = '{e[2], 0, -e[0]};
            void'(normalise(w, tmp, a2));
            a3 = cross_unit(a1, a2);
        end
        for (int i = 0; i < 3; i++) begin
            f.axis[i]     = f.degen ? 0 : a1[i];
            f.axis[3 + i] = f.degen ? 0 : a2[i];
            f.axis[6 + i] = f.degen ? 0 : a3[i];
        end
        return f;
    endfunction

    // sender
    element_t cur;
    int       send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                frames_due.push_back(build_frame(cur));
                n_sent++;
            end
            if (!(i_valid && o_stall)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_elements.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (pending_elements[0].pause && frames_due.size() > 0) begin
                    i_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(1, 11) - 1;
                    i_valid <= 1'b0;
                end else begin
                    cur = pending_elements.pop_front();
                    i_node_a_x <= cur.ax;
                    i_node_a_y <= cur.ay;
                    i_node_a_z <= cur.az;
                    i_node_b_x <= cur.bx;
                    i_node_b_y <= cur.by;
                    i_node_b_z <= cur.bz;
                    i_use_reference <= cur.use_ref;
                    i_ref_x <= cur.rx;
                    i_ref_y <= cur.ry;
                    i_ref_z <= cur.rz;
                    i_valid <= 1'b1;
                end
            end
        end
    end

    // receiver and checker
    int  recv_gap = 0;
    int  hold_left = 0;
    bit  held_once = 0;
    always @(posedge i_clk) begin
        frame_t f;
        logic signed [15:0] got [9];
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got = '{o_axis1_x, o_axis1_y, o_axis1_z, o_axis2_x, o_axis2_y,
                        o_axis2_z, o_axis3_x, o_axis3_y, o_axis3_z};
                if (frames_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transfer, length %0d", $time, o_length);
                end else begin
                    f = frames_due.pop_front();
                    if (o_length !== f.len) begin
                        errors++;
                        $display("%0t: length expected %0d actual %0d", $time, f.len, o_length);
                    end
                    for (int i = 0; i < 9; i++)
                        if (got[i] !== 16'(f.axis[i])) begin
                            errors++;
                            $display("%0t: axis%0d_%0d expected %0d actual %0d", $time,
                                     i / 3 + 1, i % 3, f.axis[i], got[i]);
                        end
                    if (o_degenerate !== f.degen) begin
                        errors++;
                        $display("%0t: degenerate expected %0b actual %0b", $time,
                                 f.degen, o_degenerate);
                    end
                end
            end
            if (n_sent >= 200 && !held_once) begin
                held_once = 1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(1, 11) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 200000) begin
            $display("beam_local_frame_builder_unit test failed");
            $finish;
        end
    end

    task automatic add_element(logic signed [31:0] ax, ay, az, bx, by, bz, logic ur,
                               logic signed [15:0] rx, ry, rz, bit pause = 0);
        element_t el;
        el = '{ax, ay, az, bx, by, bz, ur, rx, ry, rz, pause};
        pending_elements.push_back(el);
    endtask

    function automatic logic signed [15:0] rand_ref();
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    initial begin
        logic signed [31:0] ax, ay, az, bx, by, bz;
        logic signed [15:0] rx, ry, rz;
        int k, sel;
        // coincident nodes
        add_element(32'sd100, -32'sd5, 32'sd7, 32'sd100, -32'sd5, 32'sd7, 0, 0, 0, 0);
        add_element(32'sd3, 32'sd3, 32'sd3, 32'sd3, 32'sd3, 32'sd3, 1, 16384, 0, 0);
        // widest spans
        add_element(32'h80000000, 32'h80000000, 32'h80000000,
                    32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0);
        add_element(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                    32'h80000000, 32'h80000000, 32'h80000000, 1, -16384, 16384, 0);
        add_element(32'h80000000, 0, 0, 32'h7fffffff, 0, 0, 0, 0, 0, 0);
        add_element(0, 32'h80000000, 0, 0, 32'h7fffffff, 0, 0, 0, 0, 0);
        add_element(0, 0, 32'h80000000, 0, 0, 32'h7fffffff, 0, 0, 0, 0);
        // smallest steps
        add_element(0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
        add_element(0, 0, 0, 0, -1, 0, 1, 0, 0, 16384);
        add_element(0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        // tie between y and z picks xz
        add_element(0, 0, 0, 32'sd5, 32'sd3, 32'sd3, 0, 0, 0, 0);
        add_element(0, 0, 0, 32'sd5, 32'sd3, -32'sd3, 0, 0, 0, 0);
        add_element(0, 0, 0, 32'sd1, 32'sd9, 32'sd2, 0, 16384, 16384, 16384);
        // parallel and zero references
        add_element(0, 0, 0, 32'sd2, 32'sd4, 32'sd6, 1, 16'sd1, 16'sd2, 16'sd3);
        add_element(0, 0, 0, 32'sd2, 32'sd4, 32'sd6, 1, -16'sd2, -16'sd4, -16'sd6);
        add_element(0, 0, 0, 32'sd65536, 0, 0, 1, 0, 0, 0);
        // out-of-range references
        add_element(0, 0, 0, 32'sd65536, 32'sd1000, 0, 1, 16'h8000, 16'h7fff, 16'h7fff);
        add_element(0, 0, 0, 32'sd7, -32'sd65536, 32'sd9, 1, 16'h7fff, 16'h8000, 16'hffff);
        add_element(32'sd1234, 0, 0, 0, 0, 32'sd99999, 1, 16384, -16384, -16384);
        for (int n = 0; n < 480; n++) begin
            sel = $urandom_range(0, 9);
            ax = $urandom;
            ay = $urandom;
            az = $urandom;
            if (sel < 3) begin
                bx = $urandom;
                by = $urandom;
                bz = $urandom;
            end else if (sel < 8) begin
                k = $urandom_range(1, 24);
                bx = ax + ($signed($urandom) >>> k);
                by = ay + ($signed($urandom) >>> k);
                bz = az + ($signed($urandom) >>> k);
            end else if (sel == 8) begin
                bx = ax;
                by = ay + ($urandom_range(0, 1) ? 32'sd0 : 32'sd1);
                bz = az;
            end else begin
                rx = $signed($urandom_range(0, 64)) - 32;
                ry = $signed($urandom_range(0, 64)) - 32;
                rz = $signed($urandom_range(0, 64)) - 32;
                k = $signed($urandom_range(0, 2000)) - 1000;
                bx = ax + rx * k;
                by = ay + ry * k;
                bz = az + rz * k;
                add_element(ax, ay, az, bx, by, bz, 1, rx, ry, rz, n == 300);
                continue;
            end
            add_element(ax, ay, az, bx, by, bz, $urandom_range(0, 1),
                        rand_ref(), rand_ref(), rand_ref(), n == 300);
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        wait (pending_elements.size() == 0 && !i_valid && frames_due.size() == 0);
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("beam_local_frame_builder_unit test passed");
        end else begin
            $display("beam_local_frame_builder_unit test failed");
        end
        $finish;
    end

endmodule
